// ----- rtl/core/assert_macros.svh -----
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/tcon_pkg.sv -----
package tcon_pkg;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] character;
    logic [4:0] row;
    logic [6:0] column;
    logic [7:0] cell_color;
  } in_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [7:0] read_color;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
  } out_t;

  typedef struct packed {
    logic [7:0] color;
    logic [7:0] chr;
  } cell_t;

  localparam logic [1:0] ACT_PRINT = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic [1:0] REG_FIRST_ROW  = 2'd0;
  localparam logic [1:0] REG_END_ROW    = 2'd1;
  localparam logic [1:0] REG_TEXT_COLOR = 2'd2;

  localparam logic [4:0] FIRST_ROW_RST  = 5'd0;
  localparam logic [4:0] END_ROW_RST    = 5'd25;
  localparam logic [7:0] TEXT_COLOR_RST = 8'd15;

  localparam logic [7:0] CH_NUL     = 8'd0;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  // extra spaces printed after the first one for a tab
  localparam logic [1:0] TAB_EXTRA = 2'd3;

endpackage

// ----- rtl/core/tcon_ram.sv -----
module tcon_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  tcon_pkg::cell_t      wdata,
  input  logic [AW-1:0]        raddr,
  output tcon_pkg::cell_t      rdata
);

  tcon_pkg::cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/text_console_teletype_top.sv -----
// Character-cell text console.
// Input: in_data is taken at a rising edge with start high and busy low. One
// item prints at the cursor (newline, tab, wrap, window scroll), writes one
// cell, clears the window rows, or reads one cell back.
// Output: exactly one result per item, shown for one cycle with out_valid
// high; read fields are zero unless the item was a read. The receiver cannot
// stall; busy falls in the same cycle the result is shown, so the next item
// can be taken then. One item is in flight at a time.
// Config: cfg_valid/cfg_ready (ready always high) write first_row, end_row,
// text_color by cfg_index; write only while busy is low.
// A scroll copies the window up one cell per cycle through the single-read-port
// screen RAM, then clears the vacated row.
// Reset: rst_n low sets cursor and registers to their reset values; afterwards
// a clearing pass zeroes the screen RAM with busy high.
module text_console_teletype_top #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  tcon_pkg::in_t    in_data,
  output logic             out_valid,
  output tcon_pkg::out_t   out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data
);

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(COLS);
  localparam int RCW   = ($clog2(ROWS + 1) > 6) ? $clog2(ROWS + 1) : 6;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRINT = 3'd1;
  localparam logic [2:0] S_PUT   = 3'd2;
  localparam logic [2:0] S_COPY  = 3'd3;
  localparam logic [2:0] S_WIPE  = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam logic [1:0] W_INIT   = 2'd0;
  localparam logic [1:0] W_WINDOW = 2'd1;
  localparam logic [1:0] W_SCROLL = 2'd2;

  function automatic logic [AW-1:0] cell_addr(input logic [RCW-1:0] r, input logic [6:0] c);
    cell_addr = AW'(32'(r) * COLS + 32'(c));
  endfunction

  logic [2:0]      state_r, state_nxt;
  tcon_pkg::in_t   item_r, item_nxt;
  logic [4:0]      cur_row_r, cur_row_nxt;
  logic [6:0]      cur_col_r, cur_col_nxt;
  logic [4:0]      first_row_r, first_row_nxt;
  logic [4:0]      end_row_r, end_row_nxt;
  logic [7:0]      text_color_r, text_color_nxt;
  logic [7:0]      ch_r, ch_nxt;
  logic [1:0]      rep_r, rep_nxt;
  logic [RCW-1:0]  sr_r, sr_nxt;
  logic [CW-1:0]   sc_r, sc_nxt;
  logic [RCW-1:0]  wend_r, wend_nxt;
  logic [1:0]      wmode_r, wmode_nxt;
  logic            pend_r, pend_nxt;
  logic [AW-1:0]   pend_addr_r, pend_addr_nxt;
  logic            out_valid_r, out_valid_nxt;
  tcon_pkg::out_t  out_r, out_nxt;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  tcon_pkg::cell_t mem_wdata;
  logic [AW-1:0]   mem_raddr;
  tcon_pkg::cell_t mem_rdata;

  logic [RCW-1:0]  lim;
  logic [4:0]      row_dec;
  logic [4:0]      row_inc;
  logic [7:0]      col_inc;
  logic [RCW-1:0]  sr_inc;
  logic            finish;
  logic [7:0]      rd_char;
  logic [7:0]      rd_color;
  logic            in_ok;
  logic            item_ok;

  tcon_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign lim     = (RCW'(end_row_r) < RCW'(ROWS)) ? RCW'(end_row_r) : RCW'(ROWS);
  assign row_dec = cur_row_r - 5'd1;
  assign row_inc = cur_row_r + 5'd1;
  assign col_inc = {1'b0, cur_col_r} + 8'd1;
  assign sr_inc  = sr_r + RCW'(1);
  assign in_ok   = (32'(in_data.row) < ROWS) && (32'(in_data.column) < COLS);
  assign item_ok = (32'(item_r.row) < ROWS) && (32'(item_r.column) < COLS);

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    first_row_nxt  = first_row_r;
    end_row_nxt    = end_row_r;
    text_color_nxt = text_color_r;
    ch_nxt         = ch_r;
    rep_nxt        = rep_r;
    sr_nxt         = sr_r;
    sc_nxt         = sc_r;
    wend_nxt       = wend_r;
    wmode_nxt      = wmode_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_raddr      = '0;
    finish         = 1'b0;
    rd_char        = '0;
    rd_color       = '0;

    if (cfg_valid) begin
      unique case (cfg_index)
        tcon_pkg::REG_FIRST_ROW:  first_row_nxt  = cfg_data[4:0];
        tcon_pkg::REG_END_ROW:    end_row_nxt    = cfg_data[4:0];
        tcon_pkg::REG_TEXT_COLOR: text_color_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt = in_data;
          unique case (in_data.action)
            tcon_pkg::ACT_PRINT: begin
              if (in_data.character == tcon_pkg::CH_NUL) begin
                state_nxt = S_FIN;
              end else begin
                ch_nxt    = (in_data.character == tcon_pkg::CH_TAB) ?
                            tcon_pkg::CH_SPACE : in_data.character;
                rep_nxt   = (in_data.character == tcon_pkg::CH_TAB) ?
                            tcon_pkg::TAB_EXTRA : 2'd0;
                state_nxt = S_PRINT;
              end
            end
            tcon_pkg::ACT_WRITE: begin
              if (in_data.character != tcon_pkg::CH_NUL && in_ok) begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(RCW'(in_data.row), in_data.column);
                mem_wdata = '{color: in_data.cell_color, chr: in_data.character};
              end
              state_nxt = S_FIN;
            end
            tcon_pkg::ACT_CLEAR: begin
              sr_nxt    = RCW'(first_row_r);
              sc_nxt    = '0;
              wend_nxt  = lim;
              wmode_nxt = W_WINDOW;
              state_nxt = S_WIPE;
            end
            default: begin
              mem_raddr = cell_addr(RCW'(in_data.row), in_data.column);
              state_nxt = S_READ;
            end
          endcase
        end
      end
      S_READ: begin
        if (item_ok) begin
          rd_char  = mem_rdata.chr;
          rd_color = mem_rdata.color;
        end
        finish = 1'b1;
      end
      S_FIN: begin
        finish = 1'b1;
      end
      S_PRINT: begin
        if (cur_row_r == end_row_r) begin
          sr_nxt    = RCW'(first_row_r);
          sc_nxt    = '0;
          state_nxt = S_COPY;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_COPY: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r;
          mem_wdata = mem_rdata;
        end
        if (sr_inc < lim) begin
          mem_raddr     = cell_addr(sr_inc, 7'(sc_r));
          pend_nxt      = 1'b1;
          pend_addr_nxt = cell_addr(sr_r, 7'(sc_r));
          if (sc_r == CW'(COLS - 1)) begin
            sc_nxt = '0;
            sr_nxt = sr_inc;
          end else begin
            sc_nxt = sc_r + CW'(1);
          end
        end else begin
          cur_row_nxt = row_dec;
          sr_nxt      = RCW'(row_dec);
          sc_nxt      = '0;
          wend_nxt    = (32'(row_dec) < ROWS) ? RCW'(row_dec) + RCW'(1) : RCW'(row_dec);
          wmode_nxt   = W_SCROLL;
          state_nxt   = S_WIPE;
        end
      end
      S_WIPE: begin
        if (sr_r < wend_r) begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr(sr_r, 7'(sc_r));
          if (sc_r == CW'(COLS - 1)) begin
            sc_nxt = '0;
            sr_nxt = sr_inc;
          end else begin
            sc_nxt = sc_r + CW'(1);
          end
        end else begin
          unique case (wmode_r)
            W_WINDOW: begin
              cur_row_nxt = first_row_r;
              finish      = 1'b1;
            end
            W_SCROLL: state_nxt = S_PUT;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_PUT: begin
        if (ch_r == tcon_pkg::CH_NEWLINE) begin
          cur_row_nxt = row_inc;
          cur_col_nxt = '0;
        end else begin
          if (32'(cur_row_r) < ROWS && 32'(cur_col_r) < COLS) begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(RCW'(cur_row_r), cur_col_r);
            mem_wdata = '{color: text_color_r, chr: ch_r};
          end
          if (32'(col_inc) >= COLS) begin
            cur_row_nxt = row_inc;
            cur_col_nxt = '0;
          end else begin
            cur_col_nxt = col_inc[6:0];
          end
        end
        if (rep_r != 2'd0) begin
          rep_nxt   = rep_r - 2'd1;
          state_nxt = S_PRINT;
        end else begin
          finish = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (finish) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
      out_nxt       = '{read_char: rd_char, read_color: rd_color,
                        cursor_row: cur_row_nxt, cursor_col: cur_col_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_WIPE;
      cur_row_r    <= tcon_pkg::FIRST_ROW_RST;
      cur_col_r    <= '0;
      first_row_r  <= tcon_pkg::FIRST_ROW_RST;
      end_row_r    <= tcon_pkg::END_ROW_RST;
      text_color_r <= tcon_pkg::TEXT_COLOR_RST;
      rep_r        <= '0;
      sr_r         <= '0;
      sc_r         <= '0;
      wend_r       <= RCW'(ROWS);
      wmode_r      <= W_INIT;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_row_r    <= cur_row_nxt;
      cur_col_r    <= cur_col_nxt;
      first_row_r  <= first_row_nxt;
      end_row_r    <= end_row_nxt;
      text_color_r <= text_color_nxt;
      rep_r        <= rep_nxt;
      sr_r         <= sr_nxt;
      sc_r         <= sc_nxt;
      wend_r       <= wend_nxt;
      wmode_r      <= wmode_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    ch_r        <= ch_nxt;
    pend_addr_r <= pend_addr_nxt;
    out_r       <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

endmodule

// ----- rtl/core/tcon_checker.sv -----
`include "assert_macros.svh"

module tcon_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  `ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  `ASSERT_IMP(a_result_idle, clk, rst_n, out_valid, !busy)
  `ASSERT_NXT(a_no_spurious, clk, rst_n, !busy && !out_valid, !out_valid)

endmodule

bind text_console_teletype_top tcon_checker u_tcon_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

// ----- dv/text_console_teletype_top_tb.sv -----
module text_console_teletype_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcon_pkg::*;

  localparam int ROWS = 25;
  localparam int COLS = 80;
  localparam int TAB_WIDTH = int'(TAB_EXTRA) + 1;
  localparam int ITEMS_PER_WINDOW = 142;
  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 16;
  localparam int NDIR = 28;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {STEP_TYPED, STEP_PREDICT, STEP_CFG} step_kind_e;

  typedef struct {
    step_kind_e kind;
    logic [1:0] reg_idx;
    logic [7:0] reg_val;
    in_t        stim;
    out_t       want;
  } step_t;

  typedef struct {
    logic [4:0] first_row;
    logic [4:0] end_row;
    logic [7:0] color;
    int         print_pct;
    int         nl_pct;
  } window_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  cell_t      screen_shadow [ROWS*COLS];
  logic [4:0] crow;
  logic [6:0] ccol;
  logic [4:0] win_first;
  logic [4:0] win_end;
  logic [7:0] print_color;

  out_t status_q [$];
  step_t directed_steps [NDIR];
  window_t windows [12];

  int n_err = 0;
  int n_res = 0;
  int n_cfg = 0;
  int n_scroll = 0;
  int n_act [4] = '{0, 0, 0, 0};
  int calm = 0;
  int quiet = 0;

  text_console_teletype_top #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic in_t item(input logic [1:0] act, input logic [7:0] ch,
                               input logic [4:0] r, input logic [6:0] c,
                               input logic [7:0] cc);
    in_t it;
    it.action = act;
    it.character = ch;
    it.row = r;
    it.column = c;
    it.cell_color = cc;
    return it;
  endfunction

  function automatic out_t status(input logic [7:0] rc, input logic [7:0] rcol,
                                  input logic [4:0] cr, input logic [6:0] cc);
    out_t st;
    st.read_char = rc;
    st.read_color = rcol;
    st.cursor_row = cr;
    st.cursor_col = cc;
    return st;
  endfunction

  function automatic step_t typed_step(input in_t it, input out_t w);
    step_t s;
    s.kind = STEP_TYPED;
    s.reg_idx = '0;
    s.reg_val = '0;
    s.stim = it;
    s.want = w;
    return s;
  endfunction

  function automatic step_t pred_step(input in_t it);
    step_t s;
    s = typed_step(it, '0);
    s.kind = STEP_PREDICT;
    return s;
  endfunction

  function automatic step_t cfg_step(input logic [1:0] idx, input logic [7:0] val);
    step_t s;
    s = typed_step('0, '0);
    s.kind = STEP_CFG;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic void put_cell(input int r, input int c, input logic [7:0] ch,
                                   input logic [7:0] color);
    if (r < ROWS && c < COLS) begin
      screen_shadow[r*COLS + c].chr = ch;
      screen_shadow[r*COLS + c].color = color;
    end
  endfunction

  function automatic void blank_row(input int r);
    if (r < ROWS) begin
      for (int c = 0; c < COLS; c++) screen_shadow[r*COLS + c] = '0;
    end
  endfunction

  function automatic void line_feed();
    crow = crow + 5'd1;
    ccol = '0;
  endfunction

  function automatic void scroll_window();
    for (int r = int'(win_first); r + 1 < int'(win_end) && r + 1 < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) screen_shadow[r*COLS + c] = screen_shadow[(r+1)*COLS + c];
    end
    crow = crow - 5'd1;
    blank_row(int'(crow));
    n_scroll++;
  endfunction

  function automatic void print_one(input logic [7:0] ch);
    if (crow == win_end) scroll_window();
    if (ch == CH_NEWLINE) begin
      line_feed();
      return;
    end
    put_cell(int'(crow), int'(ccol), ch, print_color);
    ccol = ccol + 7'd1;
    if (int'(ccol) >= COLS) line_feed();
  endfunction

  function automatic out_t console_update(input in_t it);
    out_t st;
    st = '0;
    case (it.action)
      ACT_PRINT: begin
        if (it.character == CH_TAB) begin
          for (int k = 0; k < TAB_WIDTH; k++) print_one(CH_SPACE);
        end else if (it.character != CH_NUL) begin
          print_one(it.character);
        end
      end
      ACT_WRITE: begin
        if (it.character != CH_NUL)
          put_cell(int'(it.row), int'(it.column), it.character, it.cell_color);
      end
      ACT_CLEAR: begin
        for (int r = int'(win_first); r < int'(win_end); r++) blank_row(r);
        crow = win_first;
      end
      ACT_READ: begin
        if (int'(it.row) < ROWS && int'(it.column) < COLS) begin
          st.read_char = screen_shadow[int'(it.row)*COLS + int'(it.column)].chr;
          st.read_color = screen_shadow[int'(it.row)*COLS + int'(it.column)].color;
        end
      end
      default: ;
    endcase
    st.cursor_row = crow;
    st.cursor_col = ccol;
    return st;
  endfunction

  function automatic int draw_gap();
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 8);
  endfunction

  function automatic in_t random_item(input int print_pct, input int nl_pct);
    in_t it;
    int pick;
    int sub;
    it.action = ACT_PRINT;
    it.character = 8'($urandom);
    it.row = 5'($urandom);
    it.column = 7'($urandom);
    it.cell_color = 8'($urandom);
    pick = $urandom_range(0, 99);
    sub = $urandom_range(0, 99);
    if (pick < print_pct) begin
      if (sub < nl_pct) it.character = CH_NEWLINE;
      else if (sub < nl_pct + 5) it.character = CH_TAB;
      else if (sub < nl_pct + 7) it.character = CH_NUL;
    end else begin
      if (sub < 40) begin
        it.action = ACT_WRITE;
        if ($urandom_range(0, 19) == 0) it.character = CH_NUL;
      end else if (sub < 45) begin
        it.action = ACT_CLEAR;
      end else begin
        it.action = ACT_READ;
      end
      if ($urandom_range(0, 4) != 0) begin
        it.row = 5'($urandom_range(0, ROWS-1));
        it.column = 7'($urandom_range(0, COLS-1));
      end
      if (it.action == ACT_READ && $urandom_range(0, 1) == 0) it.row = crow;
    end
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    n_err++;
    if (n_err <= 50) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic send_item(input in_t it, input bit use_want, input out_t want);
    int gap;
    out_t pred;
    gap = draw_gap();
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = console_update(it);
    status_q.push_back(use_want ? want : pred);
    n_act[it.action]++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    int gap;
    gap = draw_gap();
    if (status_q.size() != 0 || busy || gap > 0) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      while (status_q.size() != 0 || busy) @(posedge clk);
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FIRST_ROW:  win_first = val[4:0];
      REG_END_ROW:    win_end = val[4:0];
      REG_TEXT_COLOR: print_color = val;
      default: ;
    endcase
    n_cfg++;
  endtask

  // result strobe cannot be held off: compare against the oldest pending status
  always @(posedge clk) begin
    out_t w;
    if (rst_n && out_valid) begin
      n_res++;
      if (status_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing pending", out_data));
      end else begin
        w = status_q.pop_front();
        if (out_data.read_char !== w.read_char)
          report_mismatch($sformatf("read_char got %h want %h", out_data.read_char, w.read_char));
        if (out_data.read_color !== w.read_color)
          report_mismatch($sformatf("read_color got %h want %h", out_data.read_color,
                                    w.read_color));
        if (out_data.cursor_row !== w.cursor_row)
          report_mismatch($sformatf("cursor_row got %0d want %0d", out_data.cursor_row,
                                    w.cursor_row));
        if (out_data.cursor_col !== w.cursor_col)
          report_mismatch($sformatf("cursor_col got %0d want %0d", out_data.cursor_col,
                                    w.cursor_col));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results pending", quiet, status_q.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    foreach (screen_shadow[i]) screen_shadow[i] = '0;
    win_first = FIRST_ROW_RST;
    win_end = END_ROW_RST;
    print_color = TEXT_COLOR_RST;
    crow = FIRST_ROW_RST;
    ccol = '0;

    directed_steps = '{
      typed_step(item(ACT_READ, 8'h00, 5'd0, 7'd0, 8'h00), status(8'h00, 8'h00, 5'd0, 7'd0)),
      typed_step(item(ACT_READ, 8'hFF, 5'd31, 7'd127, 8'hFF), status(8'h00, 8'h00, 5'd0, 7'd0)),
      typed_step(item(ACT_PRINT, CH_NUL, 5'd0, 7'd0, 8'h00), status(8'h00, 8'h00, 5'd0, 7'd0)),
      typed_step(item(ACT_WRITE, CH_NUL, 5'd2, 7'd3, 8'hFF), status(8'h00, 8'h00, 5'd0, 7'd0)),
      typed_step(item(ACT_READ, 8'h00, 5'd2, 7'd3, 8'h00), status(8'h00, 8'h00, 5'd0, 7'd0)),
      typed_step(item(ACT_PRINT, 8'h41, 5'd0, 7'd0, 8'h00), status(8'h00, 8'h00, 5'd0, 7'd1)),
      typed_step(item(ACT_READ, 8'h00, 5'd0, 7'd0, 8'h00), status(8'h41, 8'h0F, 5'd0, 7'd1)),
      typed_step(item(ACT_WRITE, 8'hFF, 5'd24, 7'd79, 8'hFF), status(8'h00, 8'h00, 5'd0, 7'd1)),
      typed_step(item(ACT_READ, 8'h00, 5'd24, 7'd79, 8'h00), status(8'hFF, 8'hFF, 5'd0, 7'd1)),
      typed_step(item(ACT_WRITE, 8'h55, 5'd25, 7'd80, 8'hAA), status(8'h00, 8'h00, 5'd0, 7'd1)),
      typed_step(item(ACT_WRITE, 8'hAA, 5'd31, 7'd127, 8'h55),
                 status(8'h00, 8'h00, 5'd0, 7'd1)),
      typed_step(item(ACT_READ, 8'h00, 5'd25, 7'd80, 8'h00), status(8'h00, 8'h00, 5'd0, 7'd1)),
      typed_step(item(ACT_PRINT, CH_TAB, 5'd0, 7'd0, 8'h00), status(8'h00, 8'h00, 5'd0, 7'd5)),
      typed_step(item(ACT_PRINT, CH_NEWLINE, 5'd0, 7'd0, 8'h00),
                 status(8'h00, 8'h00, 5'd1, 7'd0)),
      typed_step(item(ACT_PRINT, 8'hFF, 5'd0, 7'd0, 8'h00), status(8'h00, 8'h00, 5'd1, 7'd1)),
      typed_step(item(ACT_CLEAR, 8'h00, 5'd0, 7'd0, 8'h00), status(8'h00, 8'h00, 5'd0, 7'd1)),
      typed_step(item(ACT_READ, 8'h00, 5'd24, 7'd79, 8'h00), status(8'h00, 8'h00, 5'd0, 7'd1)),
      cfg_step(REG_FIRST_ROW, 8'd22),
      cfg_step(REG_END_ROW, 8'd24),
      cfg_step(REG_TEXT_COLOR, 8'hC3),
      pred_step(item(ACT_CLEAR, 8'h00, 5'd0, 7'd0, 8'h00)),
      pred_step(item(ACT_PRINT, 8'h78, 5'd0, 7'd0, 8'h00)),
      pred_step(item(ACT_PRINT, CH_NEWLINE, 5'd0, 7'd0, 8'h00)),
      pred_step(item(ACT_PRINT, CH_NEWLINE, 5'd0, 7'd0, 8'h00)),
      pred_step(item(ACT_PRINT, 8'h79, 5'd0, 7'd0, 8'h00)),
      pred_step(item(ACT_READ, 8'h00, 5'd23, 7'd0, 8'h00)),
      pred_step(item(ACT_READ, 8'h00, 5'd22, 7'd1, 8'h00)),
      pred_step(item(ACT_PRINT, CH_TAB, 5'd0, 7'd0, 8'h00))
    };

    // first row, end row, color, print share, newline share
    windows = '{
      '{5'd0,  5'd25, 8'h0F, 60, 4},
      '{5'd0,  5'd1,  8'h00, 70, 8},
      '{5'd24, 5'd25, 8'hFF, 85, 0},
      '{5'd10, 5'd13, 8'hA5, 85, 1},
      '{5'd0,  5'd31, 8'h3C, 60, 5},
      '{5'd20, 5'd5,  8'h5A, 60, 6},
      '{5'd12, 5'd12, 8'h80, 60, 6},
      '{5'd0,  5'd0,  8'h01, 50, 6},
      '{5'd31, 5'd31, 8'hFE, 50, 6},
      '{5'd3,  5'd7,  8'h77, 85, 0},
      '{5'd23, 5'd25, 8'h0F, 70, 3},
      '{5'd0,  5'd25, 8'hE1, 85, 1}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      case (directed_steps[i].kind)
        STEP_CFG:   write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
        STEP_TYPED: send_item(directed_steps[i].stim, 1'b1, directed_steps[i].want);
        default:    send_item(directed_steps[i].stim, 1'b0, '0);
      endcase
    end

    foreach (windows[p]) begin
      write_reg(REG_UNUSED, 8'($urandom));
      write_reg(REG_FIRST_ROW, {3'($urandom), windows[p].first_row});
      write_reg(REG_END_ROW, {3'($urandom), windows[p].end_row});
      write_reg(REG_TEXT_COLOR, windows[p].color);
      repeat (ITEMS_PER_WINDOW)
        send_item(random_item(windows[p].print_pct, windows[p].nl_pct), 1'b0, '0);
    end

    start <= 1'b0;
    cfg_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d prints, %0d cell writes, %0d window clears, %0d reads; %0d scrolls",
             n_act[ACT_PRINT], n_act[ACT_WRITE], n_act[ACT_CLEAR], n_act[ACT_READ], n_scroll);
    $display("%0d register writes over %0d window settings, %0d results, %0d mismatches",
             n_cfg, $size(windows), n_res, n_err);
    if (n_err == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
